@@ rtl/psd_pkg.sv @@
// shared types and constants for the power series divider
package psd_pkg;

	localparam int COEF_W    = 32;               // coefficient word
	localparam int FRAC_W    = 16;               // fraction bits of a coefficient
	localparam int PROD_W    = 2 * COEF_W;       // one tap product
	localparam int ACC_W     = PROD_W + 4;       // exact sum of six products and the numerator
	localparam int DVD_W     = PROD_W;           // dividend magnitude after the range check
	localparam int QUO_W     = COEF_W + 1;       // quotient bits worked out serially
	localparam int COEF_REGS = 7;                // denominator coefficient registers
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEN_LEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_0 = 3'd1;

	localparam logic [COEF_W-1:0] SAT_POS  = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] SAT_NEG  = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [COEF_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             too_big;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/power_series_division.sv @@
// top level of the power series divider: sequencer, multiply-accumulate and history
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: num_coef; tlast: last_term
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: series_coef; tuser: overflow, div_zero;
//                                             tlast: last_out
// cfg      in   cfg_wen (no wait)             cfg_index, cfg_data
//
// an item passes idle, the taps, the range check, the divide and the result; the serial
// divider (one quotient bit a cycle) sets most of it, the single multiplier one cycle a tap
// a zero den_coef_0 skips the arithmetic and goes straight to the result
// reset sets den_len to 1, den_coef_0 to 1.0, other coefficients and history to zero
// s_axis_tready is high only while idle; a finished result sits in the output register,
// so the next item is taken while it waits, and is held back at the end until it drains
module power_series_division #(
	parameter int MAX_DEN_LEN = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] num_coef
	input  logic        s_axis_tlast,
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] series_coef
	output logic [1:0]  m_axis_tuser,   // [0] overflow, [1] div_zero
	output logic        m_axis_tlast,
	// configuration writes
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW      = psd_pkg::COEF_W;
	localparam int AW      = psd_pkg::ACC_W;
	localparam int TAP_MAX = (MAX_DEN_LEN < psd_pkg::COEF_REGS) ? MAX_DEN_LEN
		: psd_pkg::COEF_REGS;
	localparam int HIST_D  = (TAP_MAX > 1) ? TAP_MAX - 1 : 1;
	localparam int IDX_W   = $clog2(TAP_MAX + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_CHECK,
		ST_DIVIDE,
		ST_RESULT
	} state_t;

	// configuration registers
	logic [psd_pkg::LEN_W-1:0] den_len_q;
	logic [CW-1:0]             den_coef_q [psd_pkg::COEF_REGS];

	// sequencer and datapath
	state_t                    state_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [psd_pkg::PROD_W-1:0] prod_q;
	logic                      last_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic                      dz_q;
	logic [CW-1:0]             w_q;
	logic [CW-1:0]             hist_q [HIST_D];

	// output register
	logic                      m_valid_q;
	logic [CW-1:0]             m_data_q;
	logic [1:0]                m_user_q;
	logic                      m_last_q;

	logic                      s_fire;
	logic                      commit;
	logic [IDX_W-1:0]          taps;
	logic [CW-1:0]             coef_sel;
	logic [CW-1:0]             past_sel;
	logic                      acc_neg;
	logic                      acc_fits;
	logic [psd_pkg::DVD_W-1:0] mag;
	logic [CW-1:0]             dmag;
	logic                      q_ovf;
	logic [CW-1:0]             q_val;
	psd_pkg::div_req_t         div_req;
	psd_pkg::div_rsp_t         div_rsp;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign commit        = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready);

	// den_len of zero counts as one, capped at the coefficients present
	always_comb begin
		if (den_len_q == '0) begin
			taps = IDX_W'(1);
		end else if (int'(den_len_q) > TAP_MAX) begin
			taps = IDX_W'(TAP_MAX);
		end else begin
			taps = IDX_W'(den_len_q);
		end
	end

	// operands of the current tap: den[l] and w[k-l]
	always_comb begin
		coef_sel = '0;
		past_sel = '0;
		for (int j = 0; j < psd_pkg::COEF_REGS; j++) begin
			if (int'(idx_q) == j) begin
				coef_sel = den_coef_q[j];
			end
		end
		for (int j = 0; j < HIST_D; j++) begin
			if (int'(idx_q) == j + 1) begin
				past_sel = hist_q[j];
			end
		end
	end

	// the exact sum must fit a signed 64-bit word before it is divided
	assign acc_neg  = acc_q[AW-1];
	assign acc_fits = (&acc_q[AW-1:psd_pkg::DVD_W-1]) | ~(|acc_q[AW-1:psd_pkg::DVD_W-1]);
	assign mag      = acc_neg ? psd_pkg::DVD_W'(-acc_q) : acc_q[psd_pkg::DVD_W-1:0];
	assign dmag     = den_coef_q[0][CW-1] ? -den_coef_q[0] : den_coef_q[0];

	assign div_req.start    = (state_q == ST_CHECK) && acc_fits;
	assign div_req.dividend = mag;
	assign div_req.divisor  = dmag;

	psd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// range of the quotient: up to 2^31 - 1 positive, 2^31 negative
	always_comb begin
		if (neg_q) begin
			q_ovf = div_rsp.too_big | div_rsp.quotient[CW]
				| (div_rsp.quotient[CW-1] & (|div_rsp.quotient[CW-2:0]));
		end else begin
			q_ovf = div_rsp.too_big | div_rsp.quotient[CW] | div_rsp.quotient[CW-1];
		end
		if (q_ovf) begin
			q_val = neg_q ? psd_pkg::SAT_NEG : psd_pkg::SAT_POS;
		end else begin
			q_val = neg_q ? -div_rsp.quotient[CW-1:0] : div_rsp.quotient[CW-1:0];
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_len_q <= psd_pkg::LEN_W'(1);
			for (int j = 0; j < psd_pkg::COEF_REGS; j++) begin
				den_coef_q[j] <= (j == 0) ? psd_pkg::COEF_ONE : '0;
			end
		end else if (cfg_wen) begin
			if (cfg_index == psd_pkg::REG_DEN_LEN) begin
				den_len_q <= cfg_data[psd_pkg::LEN_W-1:0];
			end else begin
				den_coef_q[cfg_index - psd_pkg::REG_DEN_COEF_0] <= cfg_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			acc_q     <= '0;
			prod_q    <= '0;
			last_q    <= 1'b0;
			neg_q     <= 1'b0;
			ovf_q     <= 1'b0;
			dz_q      <= 1'b0;
			w_q       <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= '0;
			m_last_q  <= 1'b0;
			for (int j = 0; j < HIST_D; j++) begin
				hist_q[j] <= '0;
			end
		end else begin
			if (m_valid_q && m_axis_tready && !commit) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						last_q <= s_axis_tlast;
						idx_q  <= IDX_W'(1);
						ovf_q  <= 1'b0;
						// numerator scaled to the products' fraction bits
						acc_q  <= $signed({{(AW - CW - psd_pkg::FRAC_W){s_axis_tdata[CW-1]}},
							s_axis_tdata, {psd_pkg::FRAC_W{1'b0}}});
						if (den_coef_q[0] == '0) begin
							dz_q    <= 1'b1;
							w_q     <= '0;
							state_q <= ST_RESULT;
						end else begin
							dz_q    <= 1'b0;
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					// product of this tap is formed while the previous one is subtracted
					if (idx_q > IDX_W'(1)) begin
						acc_q <= acc_q - AW'(prod_q);
					end
					if (idx_q < taps) begin
						prod_q <= $signed(coef_sel) * $signed(past_sel);
						idx_q  <= idx_q + IDX_W'(1);
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					neg_q <= acc_neg ^ den_coef_q[0][CW-1];
					if (acc_fits) begin
						state_q <= ST_DIVIDE;
					end else begin
						ovf_q   <= 1'b1;
						w_q     <= (acc_neg ^ den_coef_q[0][CW-1]) ? psd_pkg::SAT_NEG
							: psd_pkg::SAT_POS;
						state_q <= ST_RESULT;
					end
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						ovf_q   <= q_ovf;
						w_q     <= q_val;
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (commit) begin
						m_valid_q <= 1'b1;
						m_data_q  <= w_q;
						m_user_q  <= {dz_q, ovf_q};
						m_last_q  <= last_q;
						// history shifts in the new term, or starts afresh after a last item
						if (last_q) begin
							for (int j = 0; j < HIST_D; j++) begin
								hist_q[j] <= '0;
							end
						end else begin
							hist_q[0] <= w_q;
							for (int j = 1; j < HIST_D; j++) begin
								hist_q[j] <= hist_q[j-1];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	// zero divisor goes straight to the result with its flag
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && den_coef_q[0] == '0) |=> (state_q == ST_RESULT && dz_q))
		else $error("zero divisor did not bypass the arithmetic");

	// the divider answers only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide step");

	// a result is never both saturated and a zero-divisor result
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("overflow and div_zero both set");

	// history is empty after a last item
	a_hist_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_q) |=> (hist_q[0] == '0))
		else $error("history not cleared after last item");

endmodule

@@ rtl/psd_div.sv @@
// serial unsigned divider, one quotient bit a cycle, with early range check
module psd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  psd_pkg::div_req_t req,
	output psd_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(psd_pkg::QUO_W);
	localparam int REM_W = psd_pkg::COEF_W + 1;

	logic                        busy_q;
	logic                        done_q;
	logic                        big_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [psd_pkg::COEF_W-1:0]  rem_q;
	logic [psd_pkg::QUO_W-1:0]   dvd_q;
	logic [psd_pkg::COEF_W-1:0]  divisor_q;
	logic [REM_W-1:0]            trial;
	logic                        ge;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[psd_pkg::QUO_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			big_q     <= 1'b0;
			cnt_q     <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			divisor_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(psd_pkg::QUO_W - 1));
			if (req.start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				divisor_q <= req.divisor;
				// upper part below the divisor keeps the quotient within QUO_W bits
				rem_q     <= psd_pkg::COEF_W'(req.dividend[psd_pkg::DVD_W-1:psd_pkg::QUO_W]);
				dvd_q     <= req.dividend[psd_pkg::QUO_W-1:0];
				big_q     <= REM_W'(req.dividend[psd_pkg::DVD_W-1:psd_pkg::QUO_W])
					>= {1'b0, req.divisor};
			end else if (busy_q) begin
				// the remainder stays below the divisor, so it fits one word
				rem_q <= ge ? psd_pkg::COEF_W'(trial - {1'b0, divisor_q})
					: trial[psd_pkg::COEF_W-1:0];
				dvd_q <= {dvd_q[psd_pkg::QUO_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(psd_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.too_big  = big_q;
	assign rsp.quotient = dvd_q;

endmodule

@@ bench/tb.sv @@
// self-checking bench for the power series divider, with random bursts and back-pressure
`timescale 1ns / 1ps

module tb;

	// one numerator term offered to the block
	typedef struct {
		logic [psd_pkg::COEF_W-1:0] num;
		logic                       last;
	} num_term_t;

	// one series coefficient as the block should return it
	typedef struct {
		logic [psd_pkg::COEF_W-1:0] coef;
		logic                       ovf;
		logic                       dz;
		logic                       last;
	} series_term_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] num_coef
	logic        s_axis_tlast = 1'b0; // last_term
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] series_coef
	logic [1:0]  m_axis_tuser;        // [0] overflow, [1] div_zero
	logic        m_axis_tlast;        // last_out
	logic        cfg_wen = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// bench copy of the block's settings and of its history of results
	logic [2:0]                        den_len_r;
	logic signed [psd_pkg::COEF_W-1:0] den_coef_r [psd_pkg::COEF_REGS];
	logic signed [psd_pkg::COEF_W-1:0] past_w [6];

	num_term_t    pending_nums[$];
	series_term_t expected_terms[$];
	int           items_queued = 0;
	int           fail_count = 0;

	// traffic shaping, changed by the stimulus between phases
	bit tx_no_gaps = 1'b0;
	bit rx_no_stalls = 1'b0;

	// driver and monitor bookkeeping
	num_term_t    next_num;
	int           burst_left = 0;
	int           gap_left = 0;
	series_term_t want;
	bit           rx_ready = 1'b0;
	int           rx_left = 0;

	power_series_division u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// next series coefficient: exact wide sum, truncating division, saturation to 32 bits
	function automatic series_term_t divide_term(input logic [psd_pkg::COEF_W-1:0] num,
		input logic last);
		series_term_t               r;
		logic signed [127:0]        acc, a, b, dd;
		logic [127:0]               acc_mag, div_mag, quo, lim;
		logic                       neg_q;
		logic [psd_pkg::COEF_W-1:0] w;
		int                         taps;
		r.ovf = 1'b0;
		r.dz = 1'b0;
		r.last = last;
		w = '0;
		// a length of zero still uses the constant term
		taps = (den_len_r == 0) ? 1 : int'(den_len_r);
		if (den_coef_r[0] == 0) begin
			r.dz = 1'b1;
		end else begin
			acc = $signed(num);
			acc = acc <<< psd_pkg::FRAC_W;
			for (int l = 1; l < taps; l++) begin
				a = den_coef_r[l];
				b = past_w[l-1];
				acc = acc - a * b;
			end
			dd = den_coef_r[0];
			acc_mag = acc[127] ? -acc : acc;
			div_mag = dd[127] ? -dd : dd;
			neg_q = acc[127] ^ dd[127];
			quo = acc_mag / div_mag;
			lim = neg_q ? 128'(psd_pkg::SAT_NEG) : 128'(psd_pkg::SAT_POS);
			if (quo > lim) begin
				r.ovf = 1'b1;
				quo = lim;
			end
			w = neg_q ? 32'(-quo) : quo[31:0];
		end
		r.coef = w;
		// the stored value is the saturated one; a last term wipes the history
		for (int i = 5; i > 0; i--)
			past_w[i] = past_w[i-1];
		past_w[0] = w;
		if (last)
			foreach (past_w[i])
				past_w[i] = '0;
		return r;
	endfunction

	// sender: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			// prediction happens when the item is taken, from the values on the bus
			if (s_axis_tvalid && s_axis_tready)
				expected_terms.push_back(divide_term(s_axis_tdata, s_axis_tlast));
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the item until it is taken
			end else if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_nums.size() != 0) begin
				next_num = pending_nums.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_num.num;
				s_axis_tlast <= next_num.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					// gaps long enough to land anywhere in one item's work
					if (tx_no_gaps)
						gap_left = 0;
					else if ($urandom_range(0, 1) == 0)
						gap_left = $urandom_range(0, 3);
					else
						gap_left = $urandom_range(4, 60);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: checks every result, stalls in runs of its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_terms.size() == 0) begin
					$error("series_coef: no result expected, got %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_terms.pop_front();
					if (m_axis_tdata !== want.coef) begin
						$error("series_coef: expected %h, got %h", want.coef, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser[0] !== want.ovf) begin
						$error("overflow: expected %b, got %b", want.ovf, m_axis_tuser[0]);
						fail_count++;
					end
					if (m_axis_tuser[1] !== want.dz) begin
						$error("div_zero: expected %b, got %b", want.dz, m_axis_tuser[1]);
						fail_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_out: expected %b, got %b", want.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (rx_left == 0) begin
				rx_ready = rx_no_stalls || ($urandom_range(0, 2) != 0);
				rx_left = rx_ready ? $urandom_range(1, 24) : $urandom_range(1, 60);
			end
			rx_left--;
			m_axis_tready <= rx_ready;
		end
	end

	// register write; the bench copy follows at once since writes happen only while idle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == psd_pkg::REG_DEN_LEN)
			den_len_r = val[2:0];
		else
			den_coef_r[idx - psd_pkg::REG_DEN_COEF_0] = val;
	endtask

	// writes every register, then releases the write enable
	task automatic load_setting(input logic [31:0] len_word,
		input logic [31:0] coefs [psd_pkg::COEF_REGS]);
		write_reg(psd_pkg::REG_DEN_LEN, len_word);
		for (int i = 0; i < psd_pkg::COEF_REGS; i++)
			write_reg(psd_pkg::REG_DEN_COEF_0 + 3'(i), coefs[i]);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic queue_term(input logic [31:0] num, input logic last);
		num_term_t t;
		t.num = num;
		t.last = last;
		pending_nums.push_back(t);
		items_queued++;
	endtask

	// sampled on the falling edge so that the rising-edge updates have settled
	task automatic drain();
		@(negedge clk);
		while (pending_nums.size() != 0 || s_axis_tvalid || expected_terms.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly small values near unity, some full range, some edge values
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom;
		if (r < 8)
			return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
		case ($urandom_range(0, 6))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return psd_pkg::SAT_POS;
			4: return psd_pkg::SAT_NEG;
			5: return psd_pkg::COEF_ONE;
			default: return -psd_pkg::COEF_ONE;
		endcase
	endfunction

	initial begin
		logic [31:0] setting [psd_pkg::COEF_REGS];
		logic [31:0] len_word;
		int          phase_target, phase_count, series_len, num_len, noise_len;
		// state after reset
		den_len_r = 3'd1;
		foreach (den_coef_r[i])
			den_coef_r[i] = '0;
		den_coef_r[0] = psd_pkg::COEF_ONE;
		foreach (past_w[i])
			past_w[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting divides by one: the result is the numerator itself
		queue_term(psd_pkg::SAT_POS, 1'b0);
		queue_term(psd_pkg::SAT_NEG, 1'b0);
		queue_term('0, 1'b0);
		queue_term('1, 1'b0);
		queue_term(32'd1, 1'b1);
		drain();

		// 1/(1-x): all ones, and a last term starts a fresh series
		setting = '{psd_pkg::COEF_ONE, -psd_pkg::COEF_ONE, '0, '0, '0, '0, '0};
		load_setting(32'd2, setting);
		queue_term(psd_pkg::COEF_ONE, 1'b0);
		queue_term('0, 1'b0);
		queue_term('0, 1'b0);
		queue_term('0, 1'b1);
		queue_term(psd_pkg::COEF_ONE, 1'b1);
		drain();

		// runaway growth: saturated values feed back through the history
		setting = '{psd_pkg::COEF_ONE, psd_pkg::SAT_NEG, '0, '0, '0, '0, '0};
		load_setting(32'd2, setting);
		queue_term(psd_pkg::COEF_ONE, 1'b0);
		queue_term('0, 1'b0);
		queue_term('0, 1'b0);
		queue_term('0, 1'b1);
		drain();

		// zero divisor with a length of zero
		setting = '{'0, psd_pkg::SAT_POS, psd_pkg::SAT_NEG, '1, 32'd1, psd_pkg::COEF_ONE,
			psd_pkg::SAT_POS};
		load_setting(32'd0, setting);
		queue_term(32'd12345, 1'b0);
		queue_term('1, 1'b1);
		drain();

		// smallest divisor overflows both ways; upper bits of the length word set
		setting = '{32'd1, '0, '0, '0, '0, '0, '0};
		load_setting(32'hffff_fff8, setting);
		queue_term(psd_pkg::SAT_POS, 1'b0);
		queue_term(psd_pkg::SAT_NEG, 1'b1);
		drain();

		// all seven taps at the extremes
		setting = '{psd_pkg::SAT_NEG, psd_pkg::SAT_POS, psd_pkg::SAT_NEG, '1, 32'd1,
			psd_pkg::SAT_POS, psd_pkg::SAT_NEG};
		load_setting(32'd7, setting);
		queue_term(psd_pkg::SAT_POS, 1'b0);
		queue_term(psd_pkg::SAT_NEG, 1'b0);
		queue_term(32'd1, 1'b0);
		queue_term(psd_pkg::COEF_ONE, 1'b1);
		drain();

		// divisor of minus one lsb: most negative numerator flips to positive overflow
		setting = '{'1, '0, '0, '0, '0, '0, '0};
		load_setting(32'd1, setting);
		queue_term(psd_pkg::SAT_NEG, 1'b0);
		queue_term(32'd1, 1'b1);
		drain();

		// random phases, each with its own setting and traffic shape
		while (items_queued < 750) begin
			len_word = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
			setting[0] = ($urandom_range(0, 2) == 0) ? pick_value()
				: (($urandom_range(0, 1) == 0) ? psd_pkg::COEF_ONE : -psd_pkg::COEF_ONE);
			for (int i = 1; i < psd_pkg::COEF_REGS; i++)
				setting[i] = pick_value();
			load_setting(len_word, setting);
			tx_no_gaps = ($urandom_range(0, 4) == 0);
			rx_no_stalls = ($urandom_range(0, 4) == 0);
			phase_target = $urandom_range(20, 60);
			phase_count = 0;
			while (phase_count < phase_target) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: unrelated terms, stray last marks
					noise_len = $urandom_range(1, 6);
					for (int k = 0; k < noise_len; k++)
						queue_term(($urandom_range(0, 1) == 0) ? $urandom : pick_value(),
							$urandom_range(0, 3) == 0);
					phase_count += noise_len;
				end else begin
					// a proper series: short numerator, zeros after it, last on the end
					series_len = $urandom_range(1, 24);
					num_len = $urandom_range(1, 4);
					for (int k = 0; k < series_len; k++)
						queue_term((k < num_len) ? pick_value() : '0, k == series_len - 1);
					phase_count += series_len;
				end
			end
			drain();
		end

		tx_no_gaps = 1'b0;
		rx_no_stalls = 1'b0;
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/psd_pkg.sv
rtl/psd_div.sv
rtl/power_series_division.sv
bench/tb.sv
